// ===== rtl/core/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_ABSORB,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic       wr_byte;
		logic [7:0] wr_data;
		logic       count_byte;
		logic       load_work;
		logic       do_round;
		logic       update_cv;
		logic       reset_msg;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0]  fill;
		logic [5:0]  round;
		logic [63:0] bit_len;
	} dp_stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_datapath.sv =====
`default_nettype none
module sha256_datapath
	import sha256_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dp_cmd_t   cmd,
	input  wire logic [2:0] rd_index,
	output dp_stat_t       stat,
	output logic [31:0]    rd_word
);

	logic [31:0] cv_q [8];
	logic [31:0] wv_q [8];
	logic [31:0] win_q [16];
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [60:0] count_q;

	logic [31:0] w, s0, s1, t1, t2, ch, maj, e1, e0;
	logic [31:0] x15, x2;

	// schedule: current word and next expansion; round functions and t1, t2
	always_comb begin
		x15 = win_q[1];
		x2  = win_q[14];
		s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
		s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
		w   = win_q[0];
		e1  = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
		ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		e0  = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
		maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1  = wv_q[7] + e1 + ch + ROUND_K[round_q] + w;
		t2  = e0 + maj;
	end

	// window: block bytes shift in one a cycle while written, then it advances per round
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			win_q[15] <= {win_q[15][23:0], cmd.wr_data};
		end else if (cmd.do_round) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= win_q[i+1];
			win_q[15] <= win_q[0] + s0 + win_q[9] + s1;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++)
				wv_q[i] <= cv_q[i];
		end else if (cmd.do_round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	// control state: chaining value, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= INIT_HASH[i];
			fill_q  <= '0;
			round_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.wr_byte)
				fill_q <= fill_q + 6'd1;
			if (cmd.count_byte)
				count_q <= count_q + 61'd1;
			if (cmd.load_work)
				round_q <= '0;
			else if (cmd.do_round)
				round_q <= round_q + 6'd1;
			if (cmd.update_cv)
				for (int i = 0; i < 8; i++)
					cv_q[i] <= cv_q[i] + wv_q[i];
			if (cmd.reset_msg) begin
				for (int i = 0; i < 8; i++)
					cv_q[i] <= INIT_HASH[i];
				fill_q  <= '0;
				count_q <= '0;
			end
		end
	end

	assign stat.fill    = fill_q;
	assign stat.round   = round_q;
	assign stat.bit_len = {count_q, 3'b000};
	assign rd_word      = cv_q[rd_index];

endmodule
`default_nettype wire

// ===== rtl/core/sha256_ctrl.sv =====
`default_nettype none
module sha256_ctrl
	import sha256_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid,
	output logic            ready,
	input  wire logic       command,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      out_index,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         cmd
);

	ctrl_state_t state_q, state_d;
	logic        fin_q;      // compression belongs to a finish
	logic        mark_q;     // pad marker written
	logic        len_here_q; // length bytes go in the current block
	logic [2:0]  idx_q;
	logic [7:0]  len_byte;
	logic        acc;

	assign acc = valid && ready;

	// length byte for the current offset, most significant first
	assign len_byte = stat.bit_len[{3'd7 - stat.fill[2:0], 3'b000} +: 8];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ABSORB:
				if (acc && command)
					state_d = ST_PAD;
				else if (acc && stat.fill == 6'd63)
					state_d = ST_LOAD;
			ST_PAD:
				if (stat.fill == 6'd63)
					state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_ROUND;
			ST_ROUND:
				if (stat.round == 6'd63)
					state_d = ST_UPDATE;
			ST_UPDATE:
				if (!fin_q)
					state_d = ST_ABSORB;
				else if (len_here_q)
					state_d = ST_EMIT;
				else
					state_d = ST_PAD;
			ST_EMIT:
				if (out_ready && idx_q == 3'd7)
					state_d = ST_ABSORB;
			default:   state_d = ST_ABSORB;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		ready     = (state_q == ST_ABSORB);
		out_valid = (state_q == ST_EMIT);
		out_index = idx_q;
		case (state_q)
			ST_ABSORB: begin
				cmd.wr_byte    = acc && !command;
				cmd.wr_data    = data_byte;
				cmd.count_byte = acc && !command;
			end
			ST_PAD: begin
				cmd.wr_byte = 1'b1;
				// marker first, then zeros, length bytes at offsets 56..63
				if (!mark_q)
					cmd.wr_data = PAD_BYTE;
				else if (len_here_q && stat.fill >= LEN_OFFSET)
					cmd.wr_data = len_byte;
				else
					cmd.wr_data = 8'h00;
			end
			ST_LOAD:   cmd.load_work = 1'b1;
			ST_ROUND:  cmd.do_round = 1'b1;
			ST_UPDATE: cmd.update_cv = 1'b1;
			ST_EMIT:   cmd.reset_msg = out_ready && idx_q == 3'd7;
			default: ;
		endcase
	end

	// pad sequencer: the length goes in the block whose marker precedes
	// offset 56, else in the following block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ABSORB;
			fin_q      <= 1'b0;
			mark_q     <= 1'b0;
			len_here_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ABSORB && acc) begin
				fin_q      <= command;
				mark_q     <= 1'b0;
				len_here_q <= 1'b0;
			end
			if (state_q == ST_PAD && !mark_q) begin
				mark_q     <= 1'b1;
				len_here_q <= (stat.fill < LEN_OFFSET);
			end
			if (state_q == ST_UPDATE && fin_q)
				len_here_q <= 1'b1;
			if (state_q == ST_EMIT && out_ready)
				idx_q <= idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Absorb: one byte per cycle; a full block then stalls input during the
// load, 64 rounds through one shared round unit, and chaining update.
// Finish: padding written one byte a cycle, one or two compressions, then
// eight digest transfers, one a cycle while out ready is high.
// Reset (arst_n low, asynchronous) restores the initial hash values and
// clears the byte count; the block buffer holds no reset value.
`default_nettype none
module sha256_byte_stream_hasher
	import sha256_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [2:0] idx;

	sha256_ctrl u_ctrl (
		.clk, .arst_n,
		.valid(in_valid), .ready(in_ready),
		.command, .data_byte,
		.out_valid, .out_ready,
		.out_index(idx),
		.stat, .cmd
	);

	sha256_datapath u_dp (
		.clk, .arst_n,
		.cmd, .rd_index(idx),
		.stat, .rd_word(digest_word)
	);

	assign word_index = idx;
	assign last_word  = (idx == 3'd7);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken during digest");
	a_round_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update_cv |-> $past(cmd.do_round)) else $error("update without rounds");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> in_ready)
		else $error("no restart after digest");

endmodule
`default_nettype wire
